// ===== rtl/core/framebuffer_pixel_glyph_engine_unit_macros.svh =====
// assertion macros used by the glyph engine rtl
`ifndef FRAMEBUFFER_PIXEL_GLYPH_ENGINE_UNIT_MACROS_SVH
`define FRAMEBUFFER_PIXEL_GLYPH_ENGINE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define FPGE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpge assertion failed");
`define FPGE_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("fpge forbidden condition seen");
`else
`define FPGE_ASSERT(lbl, clk, rst_n, prop)
`define FPGE_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/fpge_pkg.sv =====
// shared constants, codes and types of the glyph engine
package fpge_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 240;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W  = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
    localparam int COL_W   = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
    localparam int ROW_W   = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
    localparam int DIM_W   = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W   = (DIM_W > 8) ? DIM_W : 8;
    localparam int COORD_W = 18;
    localparam int COLOR_W = 16;
    localparam int GLYPH_W = 8;
    localparam int GLYPH_IW = 3;
    localparam logic [3:0] USED_MAX = 4'd8;

    typedef enum logic [2:0] {
        ACT_CLEAR = 3'd0,
        ACT_PLOT  = 3'd1,
        ACT_FILL  = 3'd2,
        ACT_READ  = 3'd3,
        ACT_GLYPH = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN_A,
        S_DRAIN_B,
        S_DONE
    } t_state;

    // one pixel visit from the sequencer
    typedef struct packed {
        logic                      we;
        logic                      rd;
        logic signed [COORD_W-1:0] col;
        logic signed [COORD_W-1:0] row;
        logic [COLOR_W-1:0]        color;
    } t_pix_req;

    // resolved store access
    typedef struct packed {
        logic               we;
        logic               rd;
        logic               inb;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
    } t_mem_req;

    typedef struct packed {
        logic [COLOR_W-1:0] data;
        logic               inb;
    } t_rd_resp;

endpackage

// ===== rtl/core/fpge_if.sv =====
// command and result channels of the glyph engine
interface fpge_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  block_size;
    logic [7:0]  glyph_bits;
    logic [3:0]  bits_used;
    logic        show_background;

    modport source (
        output valid, action, pos_x, pos_y, fg_color, bg_color,
               block_size, glyph_bits, bits_used, show_background,
        input  ready
    );
    modport sink (
        input  valid, action, pos_x, pos_y, fg_color, bg_color,
               block_size, glyph_bits, bits_used, show_background,
        output ready
    );
endinterface

interface fpge_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_color;
    logic        read_in_bounds;

    modport source (output valid, pixel_color, read_in_bounds, input ready);
    modport sink   (input valid, pixel_color, read_in_bounds, output ready);
endinterface

// ===== rtl/core/fpge_addr_unit.sv =====
// shared clip and address unit: one pixel coordinate per cycle into a store address
module fpge_addr_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fpge_pkg::t_pix_req  i_pix,
    output fpge_pkg::t_mem_req  o_mem
);

    logic                            n_inb;
    logic [fpge_pkg::ADDR_W-1:0]     n_addr;
    logic                            r_we;
    logic                            r_rd;
    logic                            r_inb;
    logic [fpge_pkg::ADDR_W-1:0]     r_addr;
    logic [fpge_pkg::COLOR_W-1:0]    r_color;

    always_comb begin
        n_inb = !i_pix.col[fpge_pkg::COORD_W-1] && !i_pix.row[fpge_pkg::COORD_W-1]
             && ($unsigned(i_pix.col) < fpge_pkg::COORD_W'(fpge_pkg::SCREEN_WIDTH))
             && ($unsigned(i_pix.row) < fpge_pkg::COORD_W'(fpge_pkg::SCREEN_HEIGHT));
        // constant row stride multiply, meaningful only when in bounds
        n_addr = fpge_pkg::ADDR_W'(fpge_pkg::ADDR_W'(i_pix.row[fpge_pkg::ROW_W-1:0])
                 * fpge_pkg::ADDR_W'(fpge_pkg::SCREEN_WIDTH))
               + fpge_pkg::ADDR_W'(i_pix.col[fpge_pkg::COL_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_we <= 1'b0;
            r_rd <= 1'b0;
        end else begin
            r_we <= i_pix.we;
            r_rd <= i_pix.rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inb   <= n_inb;
        r_addr  <= n_addr;
        r_color <= i_pix.color;
    end

    assign o_mem = '{we: r_we, rd: r_rd, inb: r_inb, addr: r_addr, color: r_color};

endmodule

// ===== rtl/core/fpge_store.sv =====
// rgb565 frame store, one access per cycle, registered read data
module fpge_store (
    input  logic                i_clk,
    input  fpge_pkg::t_mem_req  i_mem,
    output fpge_pkg::t_rd_resp  o_rd
);

    logic [fpge_pkg::COLOR_W-1:0] r_mem [fpge_pkg::PIXEL_COUNT];
    logic [fpge_pkg::COLOR_W-1:0] r_rdata;
    logic                         r_rd_inb;

    always_ff @(posedge i_clk) begin
        if (i_mem.we && i_mem.inb) begin
            r_mem[i_mem.addr] <= i_mem.color;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mem.rd) begin
            r_rd_inb <= i_mem.inb;
            if (i_mem.inb) begin
                r_rdata <= r_mem[i_mem.addr];
            end
        end
    end

    assign o_rd = '{data: r_rdata, inb: r_rd_inb};

endmodule

// ===== rtl/core/fpge_seq.sv =====
// command sequencer: walks the pixels of a command and holds the result register
`include "framebuffer_pixel_glyph_engine_unit_macros.svh"
module fpge_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    fpge_cmd_if.sink            i_cmd,
    fpge_res_if.source          o_res,
    output fpge_pkg::t_pix_req  o_pix,
    input  fpge_pkg::t_rd_resp  i_rd
);

    fpge_pkg::t_state                     r_state, n_state;
    logic [2:0]                           r_act, n_act;
    logic signed [fpge_pkg::COORD_W-1:0]  r_x, n_x, r_y, n_y;
    logic [fpge_pkg::COLOR_W-1:0]         r_fore, n_fore, r_back, n_back;
    logic [fpge_pkg::GLYPH_W-1:0]         r_glyph, n_glyph;
    logic                                 r_show_bg, n_show_bg;
    logic [fpge_pkg::CNT_W-1:0]           r_cnt_c, n_cnt_c, r_cnt_r, n_cnt_r;
    logic [fpge_pkg::CNT_W-1:0]           r_last_c, n_last_c, r_last_r, n_last_r;
    logic                                 r_out_valid, n_out_valid;
    logic [fpge_pkg::COLOR_W-1:0]         r_out_color, n_out_color;
    logic                                 r_out_inb, n_out_inb;

    logic                                 accept;
    logic                                 load;
    logic                                 fill_ok;
    logic                                 glyph_set;
    logic [3:0]                           used_sat;
    logic signed [fpge_pkg::COORD_W-1:0]  x_in, y_in, x_end, y_end;
    logic [fpge_pkg::GLYPH_IW-1:0]        glyph_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpge_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act       <= n_act;
        r_x         <= n_x;
        r_y         <= n_y;
        r_fore      <= n_fore;
        r_back      <= n_back;
        r_glyph     <= n_glyph;
        r_show_bg   <= n_show_bg;
        r_cnt_c     <= n_cnt_c;
        r_cnt_r     <= n_cnt_r;
        r_last_c    <= n_last_c;
        r_last_r    <= n_last_r;
        r_out_color <= n_out_color;
        r_out_inb   <= n_out_inb;
    end

    assign accept      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == fpge_pkg::S_IDLE);
    assign load        = (r_state == fpge_pkg::S_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid          = r_out_valid;
    assign o_res.pixel_color    = r_out_color;
    assign o_res.read_in_bounds = r_out_inb;

    always_comb begin
        x_in  = fpge_pkg::COORD_W'(i_cmd.pos_x);
        y_in  = fpge_pkg::COORD_W'(i_cmd.pos_y);
        x_end = x_in + $signed(fpge_pkg::COORD_W'(i_cmd.block_size));
        y_end = y_in + $signed(fpge_pkg::COORD_W'(i_cmd.block_size));
        fill_ok = !i_cmd.pos_x[15] && !i_cmd.pos_y[15] && (i_cmd.block_size != 8'd0)
               && (x_end <= $signed(fpge_pkg::COORD_W'(fpge_pkg::SCREEN_WIDTH)))
               && (y_end <= $signed(fpge_pkg::COORD_W'(fpge_pkg::SCREEN_HEIGHT)));
        used_sat = (i_cmd.bits_used > fpge_pkg::USED_MAX) ? fpge_pkg::USED_MAX
                                                          : i_cmd.bits_used;
        // glyph rows go msb first
        glyph_idx = ~r_cnt_r[fpge_pkg::GLYPH_IW-1:0];
        glyph_set = r_glyph[glyph_idx];
    end

    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_x         = r_x;
        n_y         = r_y;
        n_fore      = r_fore;
        n_back      = r_back;
        n_glyph     = r_glyph;
        n_show_bg   = r_show_bg;
        n_cnt_c     = r_cnt_c;
        n_cnt_r     = r_cnt_r;
        n_last_c    = r_last_c;
        n_last_r    = r_last_r;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_color = r_out_color;
        n_out_inb   = r_out_inb;

        o_pix.we    = 1'b0;
        o_pix.rd    = 1'b0;
        o_pix.col   = r_x + $signed(fpge_pkg::COORD_W'(r_cnt_c));
        o_pix.row   = r_y + $signed(fpge_pkg::COORD_W'(r_cnt_r));
        o_pix.color = r_fore;

        unique case (r_state)
            fpge_pkg::S_IDLE: begin
                if (accept) begin
                    n_act     = i_cmd.action;
                    n_x       = x_in;
                    n_y       = y_in;
                    n_fore    = i_cmd.fg_color;
                    n_back    = i_cmd.bg_color;
                    n_glyph   = i_cmd.glyph_bits;
                    n_show_bg = i_cmd.show_background;
                    n_cnt_c   = '0;
                    n_cnt_r   = '0;
                    n_last_c  = '0;
                    n_last_r  = '0;
                    n_state   = fpge_pkg::S_DONE;
                    unique case (i_cmd.action)
                        fpge_pkg::ACT_CLEAR: begin
                            n_x      = '0;
                            n_y      = '0;
                            n_last_c = fpge_pkg::CNT_W'(fpge_pkg::SCREEN_WIDTH - 1);
                            n_last_r = fpge_pkg::CNT_W'(fpge_pkg::SCREEN_HEIGHT - 1);
                            n_state  = fpge_pkg::S_WALK;
                        end
                        fpge_pkg::ACT_PLOT, fpge_pkg::ACT_READ: begin
                            n_state = fpge_pkg::S_WALK;
                        end
                        fpge_pkg::ACT_FILL: begin
                            n_last_c = fpge_pkg::CNT_W'(i_cmd.block_size)
                                     - fpge_pkg::CNT_W'(1);
                            n_last_r = n_last_c;
                            if (fill_ok) begin
                                n_state = fpge_pkg::S_WALK;
                            end
                        end
                        fpge_pkg::ACT_GLYPH: begin
                            n_last_r = fpge_pkg::CNT_W'(used_sat) - fpge_pkg::CNT_W'(1);
                            if (used_sat != 4'd0) begin
                                n_state = fpge_pkg::S_WALK;
                            end
                        end
                        default: begin
                            n_state = fpge_pkg::S_DONE;
                        end
                    endcase
                end
            end
            fpge_pkg::S_WALK: begin
                unique case (r_act)
                    fpge_pkg::ACT_READ: begin
                        o_pix.rd = 1'b1;
                    end
                    fpge_pkg::ACT_GLYPH: begin
                        o_pix.we    = !glyph_set || r_show_bg;
                        o_pix.color = glyph_set ? r_back : r_fore;
                    end
                    default: begin
                        o_pix.we = 1'b1;
                    end
                endcase
                if (r_cnt_c == r_last_c) begin
                    n_cnt_c = '0;
                    n_cnt_r = r_cnt_r + fpge_pkg::CNT_W'(1);
                    if (r_cnt_r == r_last_r) begin
                        n_state = fpge_pkg::S_DRAIN_A;
                    end
                end else begin
                    n_cnt_c = r_cnt_c + fpge_pkg::CNT_W'(1);
                end
            end
            fpge_pkg::S_DRAIN_A: begin
                n_state = fpge_pkg::S_DRAIN_B;
            end
            fpge_pkg::S_DRAIN_B: begin
                n_state = fpge_pkg::S_DONE;
            end
            fpge_pkg::S_DONE: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_inb   = (r_act == fpge_pkg::ACT_READ) && i_rd.inb;
                    n_out_color = n_out_inb ? i_rd.data : '0;
                    n_state     = fpge_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpge_pkg::S_IDLE;
            end
        endcase
    end

    `FPGE_ASSERT(a_accept_leaves_idle, i_clk, i_rst_n, accept |=> (r_state != fpge_pkg::S_IDLE))
    `FPGE_ASSERT_NEVER(a_access_outside_walk, i_clk, i_rst_n, (r_state != fpge_pkg::S_WALK) && (o_pix.we || o_pix.rd))
    `FPGE_ASSERT(a_inb_only_for_read, i_clk, i_rst_n, (load && (r_act != fpge_pkg::ACT_READ)) |=> !r_out_inb)
    `FPGE_ASSERT(a_load_sets_valid, i_clk, i_rst_n, load |=> (r_out_valid && (r_state == fpge_pkg::S_IDLE)))

endmodule

// ===== rtl/core/framebuffer_pixel_glyph_engine_unit.sv =====
// Frame store and drawing engine for a 320 x 240 RGB565 screen. Each command item
// (clear, plot, block fill, pixel read, glyph byte) returns one result item; only a
// read returns a pixel, with an on-screen flag. Every pixel a command touches goes
// one per cycle through a shared clip and address unit into a single-port store;
// a command visits one pixel for a plot or read, up to eight for a glyph byte,
// size*size for a drawn block and 76800 for a clear. Rejected blocks, empty glyph
// bytes and unknown actions visit none. The next command is taken while a result
// still waits on the output.
// Pixels are only defined once written, so read after a clear.
module framebuffer_pixel_glyph_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fpge_cmd_if.sink    i_cmd,
    fpge_res_if.source  o_res
);

    fpge_pkg::t_pix_req pix;
    fpge_pkg::t_mem_req mem;
    fpge_pkg::t_rd_resp rd;

    fpge_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .o_pix   (pix),
        .i_rd    (rd)
    );

    fpge_addr_unit u_addr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_mem   (mem)
    );

    fpge_store u_store (
        .i_clk (i_clk),
        .i_mem (mem),
        .o_rd  (rd)
    );

endmodule
